// File: rtl/core/lagr_pkg.sv
`timescale 1ns / 1ps
package lagr_pkg;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned DEG_W = 2;
   localparam int unsigned SUM_W = 34;
   localparam int unsigned ACC_W = 68;
   localparam int unsigned Y_W = ACC_W - 16;

   localparam logic [DEG_W-1:0] DEGREE_ONE = 2'd1;
   localparam logic [DEG_W-1:0] DEGREE_THREE = 2'd3;
   localparam logic [DEG_W-1:0] DEGREE_RESET = DEGREE_THREE;

   localparam logic signed [SUM_W-1:0] ONE_Q16 = 34'sd65536;
   localparam logic signed [ACC_W-1:0] HALF_LSB = 68'sd32768;
   localparam logic signed [Y_W-1:0] Y_MAX = 52'sd2147483647;
   localparam logic signed [Y_W-1:0] Y_MIN = -52'sd2147483648;
endpackage

// File: rtl/core/lagrange_interpolator.sv
`timescale 1ns / 1ps
// channel | ports                                        | direction
// req     | req_valid, req_stall, node_a..d, query_point | in
// rsp     | rsp_valid, rsp_stall, interpolated, flags    | out
// csr     | csr_write_enable, csr_write_data (degree)    | in
//
// four register stages: operand prep, multiply, sum and round, saturate/output
// one transaction per cycle while the output is not stalled
// reset (synchronous) clears valid bits and sets degree to 3
// a stalled output freezes the whole pipe, so req_stall follows it
module lagrange_interpolator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [lagr_pkg::DEG_W-1:0]      csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [lagr_pkg::DATA_W-1:0] req_node_a,
   input  logic signed [lagr_pkg::DATA_W-1:0] req_node_b,
   input  logic signed [lagr_pkg::DATA_W-1:0] req_node_c,
   input  logic signed [lagr_pkg::DATA_W-1:0] req_node_d,
   input  logic signed [lagr_pkg::DATA_W-1:0] req_query_point,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [lagr_pkg::DATA_W-1:0] rsp_interpolated,
   output logic                            rsp_divide_error,
   output logic                            rsp_saturated
);
   import lagr_pkg::*;

   logic [DEG_W-1:0] degree_ff;
   logic advance;

   // stage 1 registers
   logic s1_valid_ff;
   logic s1_clash_ff, s1_lin_ff;
   logic signed [SUM_W-1:0] s1_sum_ff;
   logic signed [DATA_W-1:0] s1_a_ff, s1_b_ff, s1_q_ff;
   // stage 2 registers
   logic s2_valid_ff;
   logic s2_clash_ff, s2_lin_ff;
   logic signed [49:0] s2_phi_ff;
   logic signed [50:0] s2_plo_ff;
   logic signed [63:0] s2_pab_ff, s2_pqq_ff;
   logic signed [DATA_W-1:0] s2_q_ff;
   // stage 3 registers
   logic s3_valid_ff, s3_clash_ff;
   logic signed [Y_W-1:0] s3_y_ff;
   // output registers
   logic rsp_valid_ff, rsp_err_ff, rsp_sat_ff;
   logic signed [DATA_W-1:0] rsp_val_ff;

   logic s1_clash_in, s1_lin_in;
   logic [DEG_W-1:0] deg_eff;
   logic signed [SUM_W-1:0] s1_sum_in;
   logic signed [15:0] qh;
   logic signed [16:0] ql;
   logic signed [ACC_W-1:0] acc_lin, acc_sq;
   logic signed [Y_W-1:0] s3_y_in;

   assign advance = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // degree 0 behaves as degree 1
   assign deg_eff = (degree_ff == '0) ? DEGREE_ONE : degree_ff;
   assign s1_lin_in = (deg_eff == DEGREE_ONE);

   always_comb begin
      s1_clash_in = (req_node_a == req_node_b);
      if (deg_eff[1]) begin
         s1_clash_in = s1_clash_in || (req_node_a == req_node_c)
                       || (req_node_b == req_node_c);
      end
      if (deg_eff == DEGREE_THREE) begin
         s1_clash_in = s1_clash_in || (req_node_a == req_node_d)
                       || (req_node_b == req_node_d) || (req_node_c == req_node_d);
      end
   end

   assign s1_sum_in = SUM_W'(req_node_a) + SUM_W'(req_node_b) + ONE_Q16;

   // query split into signed high half and unsigned low half
   assign qh = s1_q_ff[31:16];
   assign ql = $signed({1'b0, s1_q_ff[15:0]});

   // degree 1: (a+b+1)*q - a*b ; higher degrees: q*q + q, both plus half lsb
   assign acc_lin = (ACC_W'(s2_phi_ff) <<< 16) + ACC_W'(s2_plo_ff)
                    - ACC_W'(s2_pab_ff) + HALF_LSB;
   assign acc_sq  = ACC_W'(s2_pqq_ff) + (ACC_W'(s2_q_ff) <<< 16) + HALF_LSB;
   assign s3_y_in = s2_lin_ff ? acc_lin[ACC_W-1:16] : acc_sq[ACC_W-1:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DEGREE_RESET;
      end else if (csr_write_enable) begin
         degree_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_clash_ff <= s1_clash_in;
         s1_lin_ff <= s1_lin_in;
         s1_sum_ff <= s1_sum_in;
         s1_a_ff <= req_node_a;
         s1_b_ff <= req_node_b;
         s1_q_ff <= req_query_point;

         s2_clash_ff <= s1_clash_ff;
         s2_lin_ff <= s1_lin_ff;
         s2_phi_ff <= 50'(s1_sum_ff) * 50'(qh);
         s2_plo_ff <= 51'(s1_sum_ff) * 51'(ql);
         s2_pab_ff <= 64'(s1_a_ff) * 64'(s1_b_ff);
         s2_pqq_ff <= 64'(s1_q_ff) * 64'(s1_q_ff);
         s2_q_ff <= s1_q_ff;

         s3_clash_ff <= s2_clash_ff;
         s3_y_ff <= s3_y_in;

         // coincident nodes force a zero value with no saturation
         rsp_err_ff <= s3_clash_ff;
         if (s3_clash_ff) begin
            rsp_val_ff <= '0;
            rsp_sat_ff <= 1'b0;
         end else if (s3_y_ff > Y_MAX) begin
            rsp_val_ff <= Y_MAX[DATA_W-1:0];
            rsp_sat_ff <= 1'b1;
         end else if (s3_y_ff < Y_MIN) begin
            rsp_val_ff <= Y_MIN[DATA_W-1:0];
            rsp_sat_ff <= 1'b1;
         end else begin
            rsp_val_ff <= s3_y_ff[DATA_W-1:0];
            rsp_sat_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_interpolated = rsp_val_ff;
   assign rsp_divide_error = rsp_err_ff;
   assign rsp_saturated = rsp_sat_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |-> rsp_interpolated == '0 && !rsp_saturated)
      else $error("divide error with nonzero value");
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_interpolated == Y_MAX[DATA_W-1:0] || rsp_interpolated == Y_MIN[DATA_W-1:0])
      else $error("saturated value not at a bound");
   a_pipe_fill: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && advance |=> rsp_valid)
      else $error("transaction lost at output stage");
endmodule

// File: bench/lagrange_interpolator_checker.sv
`timescale 1ns / 1ps
module lagrange_interpolator_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [lagr_pkg::DEG_W-1:0]            csr_write_data,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [lagr_pkg::DATA_W-1:0]    req_node_a,
   input  logic signed [lagr_pkg::DATA_W-1:0]    req_node_b,
   input  logic signed [lagr_pkg::DATA_W-1:0]    req_node_c,
   input  logic signed [lagr_pkg::DATA_W-1:0]    req_node_d,
   input  logic signed [lagr_pkg::DATA_W-1:0]    req_query_point,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic signed [lagr_pkg::DATA_W-1:0]    rsp_interpolated,
   input  logic                                  rsp_divide_error,
   input  logic                                  rsp_saturated,
   output int                                    fail_count,
   output int                                    pending_count
);
   import lagr_pkg::*;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     div_err;
      logic                     sat;
   } interp_type;

   logic [DEG_W-1:0] degree_ff;
   interp_type       interp_fifo[$];

   // round to nearest, half toward +inf
   function automatic longint round_q16(longint v);
      longint t;
      longint q;
      t = v + 32768;
      q = t / 65536;
      if (t % 65536 != 0 && t < 0) q = q - 1;
      return q;
   endfunction

   function automatic interp_type predict_interp(logic [DEG_W-1:0] dg,
         longint a, longint b, longint c, longint d, longint q);
      interp_type r;
      int      n;
      logic    clash;
      longint  y, s, ql, qh;
      n = (dg == 0) ? 1 : dg;
      clash = (a == b);
      if (n >= 2) clash = clash || a == c || b == c;
      if (n >= 3) clash = clash || a == d || b == d || c == d;
      r = '0;
      if (clash) begin
         r.div_err = 1'b1;
         return r;
      end
      if (n == 1) begin
         s  = a + b + 65536;
         ql = q & 64'hFFFF;
         qh = (q - ql) / 65536;
         y  = s * qh + round_q16(s * ql - a * b);
      end else begin
         y = q + round_q16(q * q);
      end
      if (y > 64'sd2147483647) begin
         y = 64'sd2147483647;
         r.sat = 1'b1;
      end else if (y < -64'sd2147483648) begin
         y = -64'sd2147483648;
         r.sat = 1'b1;
      end
      r.value = y[DATA_W-1:0];
      return r;
   endfunction

   assign pending_count = interp_fifo.size();

   always @(posedge clock) begin
      interp_type exp_r;
      if (reset) begin
         degree_ff  <= DEGREE_RESET;
         fail_count <= 0;
         interp_fifo.delete();
      end else begin
         if (csr_write_enable) degree_ff <= csr_write_data;
         if (req_valid && !req_stall)
            interp_fifo.push_back(predict_interp(degree_ff, req_node_a, req_node_b,
               req_node_c, req_node_d, req_query_point));
         if (rsp_valid && !rsp_stall) begin
            if (interp_fifo.size() == 0) begin
               $display("%t: unexpected transaction, actual %h/%b/%b", $time,
                  rsp_interpolated, rsp_divide_error, rsp_saturated);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = interp_fifo.pop_front();
               if (exp_r.value !== rsp_interpolated || exp_r.div_err !== rsp_divide_error
                     || exp_r.sat !== rsp_saturated) begin
                  $display("%t: mismatch, expected %h/%b/%b actual %h/%b/%b", $time,
                     exp_r.value, exp_r.div_err, exp_r.sat,
                     rsp_interpolated, rsp_divide_error, rsp_saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// File: bench/lagrange_interpolator_tb.sv
`timescale 1ns / 1ps
module lagrange_interpolator_tb;
   import lagr_pkg::*;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [DEG_W-1:0] csr_write_data;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic signed [DATA_W-1:0] req_node_a, req_node_b, req_node_c, req_node_d;
   logic signed [DATA_W-1:0] req_query_point, rsp_interpolated;
   logic rsp_divide_error, rsp_saturated;
   int fail_count, pending_count;
   // idle percentages for sender and receiver
   int send_idle_pct, recv_stall_pct;

   localparam logic [DEG_W-1:0] DEGREE_TWO  = 2'd2;
   localparam logic [DEG_W-1:0] DEGREE_ZERO = 2'd0;

   lagrange_interpolator dut (.*);

   lagrange_interpolator_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   // receiver side stalls at random by phase
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // random node value, biased toward small magnitudes and edges
   function automatic logic [DATA_W-1:0] rand_node();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom;
         3: return $urandom_range(4);
         4: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
         default: return {{8{$urandom_range(1) == 1}}, 24'($urandom)};
      endcase
   endfunction

   // one transaction, held until accepted; valid stays high for a back-to-back follower
   task automatic send_item(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
         logic [DATA_W-1:0] c, logic [DATA_W-1:0] d, logic [DATA_W-1:0] q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_node_a      <= a;
      req_node_b      <= b;
      req_node_c      <= c;
      req_node_d      <= d;
      req_query_point <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending, wait for the pipe to drain, then set a new degree
   task automatic set_degree(logic [DEG_W-1:0] dg);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= dg;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_items(int count);
      logic [DATA_W-1:0] a, b, c, d;
      repeat (count) begin
         a = rand_node();
         b = rand_node();
         c = rand_node();
         d = rand_node();
         // now and then force a node clash
         case ($urandom_range(11))
            0: b = a;
            1: c = b;
            2: d = a;
            3: d = c;
            default: ;
         endcase
         send_item(a, b, c, d, rand_node());
      end
   endtask

   initial begin
      logic [DEG_W-1:0] deg_list[4];
      deg_list = '{DEGREE_ONE, DEGREE_TWO, DEGREE_THREE, DEGREE_ZERO};
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_node_a       = '0;
      req_node_b       = '0;
      req_node_c       = '0;
      req_node_d       = '0;
      req_query_point  = '0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset degree, then degrees one, two and zero; extremes, clashes, overflow
      send_item(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0000_8000);
      send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'h7FFF_FFFF);
      send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'h8000_0000);
      send_item(32'h1, 32'h2, 32'h3, 32'h1, 32'h0);
      send_item(32'h1, 32'h2, 32'h3, 32'h3, 32'h0);
      send_item(32'h5, 32'h5, 32'h3, 32'h4, 32'h0);
      send_item(32'hFFFF_FFFF, 32'h0, 32'h1, 32'h2, 32'hFFFF_8000);
      send_item(32'h1, 32'h2, 32'h3, 32'h4, 32'h00B5_0000);
      set_degree(DEGREE_ONE);
      send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'h1, 32'h7FFF_FFFF);
      send_item(32'h8000_0000, 32'h8000_0000, 32'h1, 32'h2, 32'h0);
      send_item(32'h7FFF_FFFF, 32'h7FFE_FFFF, 32'h1, 32'h1, 32'h8000_0000);
      send_item(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0000_8000);
      send_item(32'h0000_0001, 32'h0000_0003, 32'h0, 32'h0, 32'hFFFF_FFFF);
      set_degree(DEGREE_TWO);
      send_item(32'h1, 32'h2, 32'h1, 32'h9, 32'h0001_0000);
      send_item(32'h1, 32'h2, 32'h3, 32'h1, 32'h8000_0000);
      set_degree(DEGREE_ZERO);
      send_item(32'h1, 32'h2, 32'h2, 32'h2, 32'h0002_0000);

      // random phases over degrees and idling patterns
      for (int phase = 0; phase < 16; phase++) begin
         set_degree(deg_list[phase % 4]);
         case ((phase / 4) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         random_items(75);
      end
      set_degree(DEGREE_THREE);

      // drain and let the pipe settle
      recv_stall_pct = 0;
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// File: sim.f
rtl/core/lagr_pkg.sv
rtl/core/lagrange_interpolator.sv
bench/lagrange_interpolator_checker.sv
bench/lagrange_interpolator_tb.sv
